// ===== hdl/cled_pkg.sv =====
// Shared types and constants of the C literal escape decoder.
package cled_pkg;

  // Operation codes of an input transaction.
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_CHAR  = 1'b1;

  // Escape phase codes.
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_OCT1 = 2'd2;
  localparam logic [1:0] PH_OCT2 = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EOF      = 3'd1;
  localparam logic [2:0] ST_NEWLINE  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_TOO_MANY = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_V  = 8'h76;

  // Depth of the result queue.
  localparam int RES_FIFO_DEPTH = 4;

  typedef struct packed {
    logic        operation;
    logic [7:0]  ch;
    logic        end_of_input;
    logic        is_char_const;
    logic        to_data;
    logic [15:0] size_limit;
  } item_t;

  typedef struct packed {
    logic [7:0]         byte_value;
    logic               byte_valid;
    logic               closed;
    logic signed [31:0] char_value;
    logic [2:0]         status;
    logic               line_advance;
    logic               is_last;
  } res_t;

  typedef struct packed {
    logic        open;
    logic [1:0]  phase;
    logic [8:0]  oct;
    logic [15:0] count;
    logic [31:0] pack_val;
    logic        kind;
    logic        into_data;
    logic [15:0] limit;
  } state_t;

  // Up to two results produced by one item.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== hdl/cled_in_if.sv =====
// Input channel of the C literal escape decoder.
interface cled_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  ch;
  logic        end_of_input;
  logic        is_char_const;
  logic        to_data;
  logic [15:0] size_limit;

  modport source (output valid, operation, ch, end_of_input, is_char_const, to_data,
                  size_limit, input ready);
  modport sink (input valid, operation, ch, end_of_input, is_char_const, to_data,
                size_limit, output ready);
endinterface

// ===== hdl/cled_out_if.sv =====
// Result channel of the C literal escape decoder.
interface cled_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         byte_value;
  logic               byte_valid;
  logic               closed;
  logic signed [31:0] char_value;
  logic [2:0]         status;
  logic               line_advance;
  logic               is_last;

  modport source (output valid, byte_value, byte_valid, closed, char_value, status,
                  line_advance, is_last, input ready);
  modport sink (input valid, byte_value, byte_valid, closed, char_value, status,
                line_advance, is_last, output ready);
endinterface

// ===== hdl/cled_step.sv =====
// Single-pass decode of one input item: next state and up to two results.
module cled_step #(
  parameter int CHAR_CONST_BYTES = 4
) (
  input  cled_pkg::item_t  item_i,
  input  cled_pkg::state_t state_i,
  output cled_pkg::state_t state_o,
  output cled_pkg::push_t  push_o
);
  import cled_pkg::*;

  localparam logic [15:0] PackBytes = 16'((CHAR_CONST_BYTES < 4) ? CHAR_CONST_BYTES : 4);
  localparam logic [15:0] MaxBytes  = 16'(CHAR_CONST_BYTES);

  typedef struct packed {
    logic        emit;
    res_t        res;
    logic [15:0] count;
    logic [31:0] pack_val;
  } dlv_t;

  function automatic logic is_octal(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic [7:0] escape_map(logic [7:0] c);
    logic [7:0] v;
    case (c)
      CH_LOW_N: v = CH_LF;
      CH_LOW_R: v = CH_CR;
      CH_LOW_B: v = CH_BS;
      CH_LOW_T: v = CH_TAB;
      CH_LOW_F: v = CH_FF;
      CH_LOW_V: v = CH_VT;
      default:  v = c;
    endcase
    return v;
  endfunction

  // One decoded byte: packed into a character constant or emitted as a string byte.
  function automatic dlv_t deliver_f(logic [7:0] b, logic [15:0] cnt, logic [31:0] pv,
                                     logic kind, logic data, logic [15:0] lim);
    dlv_t        d;
    logic [31:0] v;
    d          = '0;
    d.count    = cnt;
    d.pack_val = pv;
    v          = {{24{b[7]}}, b};
    if (kind) begin
      if (cnt < PackBytes) begin
        case (cnt[1:0])
          2'd0:    d.pack_val = v;
          2'd1:    d.pack_val = {v[23:0], pv[7:0]};
          2'd2:    d.pack_val = {v[15:0], pv[15:0]};
          default: d.pack_val = {v[7:0], pv[23:0]};
        endcase
      end
    end else if (!data || (lim == 16'd0) || (cnt < lim)) begin
      d.emit           = 1'b1;
      d.res.byte_value = b;
      d.res.byte_valid = 1'b1;
    end else if (cnt == lim) begin
      d.emit       = 1'b1;
      d.res.status = ST_IGNORED;
    end
    if (cnt != 16'hFFFF) begin
      d.count = cnt + 16'd1;
    end
    return d;
  endfunction

  // Closing result of a constant.
  function automatic res_t close_f(logic [2:0] status, logic line, logic [15:0] cnt,
                                   logic [31:0] pv, logic kind, logic data,
                                   logic [15:0] lim);
    res_t r;
    r              = '0;
    r.closed       = 1'b1;
    r.line_advance = line;
    r.status       = status;
    if (kind) begin
      if (status == ST_OK) begin
        if (cnt == 16'd0) begin
          r.status = ST_EMPTY;
        end else if (cnt > MaxBytes) begin
          r.status = ST_TOO_MANY;
        end
      end
      r.char_value = pv;
    end else begin
      r.byte_valid = !data || (lim == 16'd0) || (cnt < lim);
    end
    return r;
  endfunction

  logic        cont_oct;
  logic        first_en;
  logic [7:0]  first_val;
  logic        plain_en;
  logic [7:0]  match;
  dlv_t        d1;
  dlv_t        d2;
  logic [15:0] cnt_m;
  logic [31:0] pk_m;
  logic        a_v;
  logic        b_v;
  res_t        a_r;
  res_t        b_r;
  state_t      nxt;

  // Escape phase handling, then an optional pending byte, then the character itself.
  always_comb begin
    nxt       = state_i;
    a_v       = 1'b0;
    b_v       = 1'b0;
    a_r       = '0;
    b_r       = '0;
    d1        = '0;
    d2        = '0;
    cnt_m     = state_i.count;
    pk_m      = state_i.pack_val;
    first_en  = 1'b0;
    first_val = state_i.oct[7:0];
    plain_en  = 1'b0;
    cont_oct  = !item_i.end_of_input && is_octal(item_i.ch);
    match     = state_i.kind ? CH_SQUOTE : CH_DQUOTE;

    if (item_i.operation == OP_BEGIN) begin
      nxt.open      = 1'b1;
      nxt.phase     = PH_NONE;
      nxt.oct       = '0;
      nxt.count     = '0;
      nxt.pack_val  = '0;
      nxt.kind      = item_i.is_char_const;
      nxt.into_data = item_i.to_data;
      nxt.limit     = item_i.size_limit;
    end else if (state_i.open) begin
      case (state_i.phase)
        PH_ESC: begin
          nxt.phase = PH_NONE;
          if (item_i.end_of_input) begin
            a_v      = 1'b1;
            a_r      = close_f(ST_EOF, 1'b0, state_i.count, state_i.pack_val,
                               state_i.kind, state_i.into_data, state_i.limit);
            nxt.open = 1'b0;
          end else if (item_i.ch == CH_LF) begin
            a_v              = 1'b1;
            a_r.line_advance = 1'b1;
          end else if (is_octal(item_i.ch)) begin
            nxt.oct   = {6'd0, item_i.ch[2:0]};
            nxt.phase = PH_OCT1;
          end else begin
            first_en  = 1'b1;
            first_val = escape_map(item_i.ch);
          end
        end
        PH_OCT1: begin
          if (cont_oct) begin
            nxt.oct   = {state_i.oct[5:0], item_i.ch[2:0]};
            nxt.phase = PH_OCT2;
          end else begin
            nxt.phase = PH_NONE;
            first_en  = 1'b1;
            plain_en  = 1'b1;
          end
        end
        PH_OCT2: begin
          nxt.phase = PH_NONE;
          first_en  = 1'b1;
          if (cont_oct) begin
            nxt.oct   = {state_i.oct[5:0], item_i.ch[2:0]};
            first_val = {state_i.oct[4:0], item_i.ch[2:0]};
          end else begin
            plain_en = 1'b1;
          end
        end
        default: plain_en = 1'b1;
      endcase

      // Pending byte from an escape or octal run.
      d1 = deliver_f(first_val, state_i.count, state_i.pack_val, state_i.kind,
                     state_i.into_data, state_i.limit);
      if (first_en) begin
        a_v   = d1.emit;
        a_r   = d1.res;
        cnt_m = d1.count;
        pk_m  = d1.pack_val;
      end
      nxt.count    = cnt_m;
      nxt.pack_val = pk_m;

      // The character as ordinary text.
      d2 = deliver_f(item_i.ch, cnt_m, pk_m, state_i.kind, state_i.into_data,
                     state_i.limit);
      if (plain_en) begin
        if (item_i.end_of_input) begin
          b_v       = 1'b1;
          b_r       = close_f(ST_EOF, 1'b0, cnt_m, pk_m, state_i.kind,
                              state_i.into_data, state_i.limit);
          nxt.open  = 1'b0;
          nxt.phase = PH_NONE;
        end else if (item_i.ch == match) begin
          b_v       = 1'b1;
          b_r       = close_f(ST_OK, 1'b0, cnt_m, pk_m, state_i.kind,
                              state_i.into_data, state_i.limit);
          nxt.open  = 1'b0;
          nxt.phase = PH_NONE;
        end else if (item_i.ch == CH_LF) begin
          b_v       = 1'b1;
          b_r       = close_f(ST_NEWLINE, 1'b1, cnt_m, pk_m, state_i.kind,
                              state_i.into_data, state_i.limit);
          nxt.open  = 1'b0;
          nxt.phase = PH_NONE;
        end else if (item_i.ch == CH_BSLASH) begin
          nxt.phase = PH_ESC;
        end else begin
          b_v          = d2.emit;
          b_r          = d2.res;
          nxt.count    = d2.count;
          nxt.pack_val = d2.pack_val;
        end
      end
    end

    a_r.is_last = !b_v;
    b_r.is_last = 1'b1;
  end

  // Compact the results so that the first one always sits in slot zero.
  assign state_o   = nxt;
  assign push_o.n  = {1'b0, a_v} + {1'b0, b_v};
  assign push_o.r0 = a_v ? a_r : b_r;
  assign push_o.r1 = b_r;

endmodule

// ===== hdl/cled_res_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one.
module cled_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_en_i,
  input  cled_pkg::push_t push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output cled_pkg::res_t  data_o
);
  import cled_pkg::*;

  localparam int PtrW = $clog2(RES_FIFO_DEPTH);
  localparam int CntW = $clog2(RES_FIFO_DEPTH + 1);

  res_t            mem_q [RES_FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      num;
  logic            pop;

  assign num     = push_en_i ? push_i.n : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(RES_FIFO_DEPTH - 2));
  assign data_o  = mem_q[rd_q];

  // Pointer and fill level update.
  assign wr_d  = wr_q + PtrW'(num);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(num) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage writes for one or two results.
  always_ff @(posedge clk_i) begin
    if (num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (num == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.r1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RES_FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num != 2'd0) |-> (cnt_q <= CntW'(RES_FIFO_DEPTH - 2)))
    else $error("result pushed without room");
`endif

endmodule

// ===== hdl/c_literal_escape_decoder.sv =====
// Top level of the C string and character constant escape decoder.
//
// Usage: src_i carries one transaction per source item. A begin item
// (operation 0) opens a constant and gives its kind, the size limit and the
// data flag; each character item (operation 1) gives one source byte or the
// end of input. res_o returns zero, one or two results per item, the last
// one marked by is_last; items that give no result produce no transaction.
// Path: an item taken into the input register is decoded into the result
// queue once the queue has room, and its results leave from the queue head.
// Throughput: one item per cycle while items give at most one result and
// res_o.ready stays high; two results of one item leave one at a time. The
// rate is set by the single result port behind a four-entry result queue.
// Reset: all constants are closed, the input register and the result queue
// are emptied.
// Stall: while res_o.ready is low the queue fills; once fewer than two
// entries are free the held item waits and src_i.ready falls.
module c_literal_escape_decoder #(
  parameter int CHAR_CONST_BYTES = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  cled_in_if.sink    src_i,
  cled_out_if.source res_o
);
  import cled_pkg::*;

  logic   in_v_q;
  item_t  in_q;
  item_t  src_item;
  state_t state_q;
  state_t state_d;
  push_t  push;
  res_t   head;
  logic   room;
  logic   fire;
  logic   take;

  assign src_item = '{operation:     src_i.operation,
                      ch:            src_i.ch,
                      end_of_input:  src_i.end_of_input,
                      is_char_const: src_i.is_char_const,
                      to_data:       src_i.to_data,
                      size_limit:    src_i.size_limit};

  // Input register: refills in the same cycle it is decoded.
  assign fire        = in_v_q && room;
  assign src_i.ready = !in_v_q || room;
  assign take        = src_i.valid && src_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (take) begin
      in_v_q <= 1'b1;
    end else if (fire) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= src_item;
    end
  end

  // Decode state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  cled_step #(
    .CHAR_CONST_BYTES(CHAR_CONST_BYTES)
  ) u_step (
    .item_i (in_q),
    .state_i(state_q),
    .state_o(state_d),
    .push_o (push)
  );

  cled_res_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_en_i(fire),
    .push_i   (push),
    .room_o   (room),
    .valid_o  (res_o.valid),
    .ready_i  (res_o.ready),
    .data_o   (head)
  );

  // Result port.
  assign res_o.byte_value   = head.byte_value;
  assign res_o.byte_valid   = head.byte_valid;
  assign res_o.closed       = head.closed;
  assign res_o.char_value   = head.char_value;
  assign res_o.status       = head.status;
  assign res_o.line_advance = head.line_advance;
  assign res_o.is_last      = head.is_last;

`ifndef SYNTHESIS
  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.closed) |-> res_o.is_last)
    else $error("closing result is not the last of its item");

  a_ignored_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == ST_IGNORED)) |-> (!res_o.byte_valid && !res_o.closed))
    else $error("ignored-byte result carries a byte or closes");

  a_begin_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_q.operation == OP_BEGIN)) |=> (state_q.open && (state_q.phase == PH_NONE)))
    else $error("begin item did not open a constant");

  a_idle_no_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.open |-> (state_q.phase == PH_NONE))
    else $error("escape pending while no constant is open");
`endif

endmodule

// ===== test/c_literal_escape_decoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the C literal escape decoder with its own decode predictor.
module c_literal_escape_decoder_tb;
  import cled_pkg::*;

  localparam int CHAR_CONST_BYTES = 4;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_ITEMS     = 180;

  // One row of the directed stimulus table.
  typedef struct {
    item_t it;
    bit    typed;
    bit    want_any;
    res_t  want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  cled_in_if  src_if ();
  cled_out_if res_if ();

  // Decoder state as the predictor sees it.
  logic        lit_open;
  logic [1:0]  esc_phase;
  logic [8:0]  oct_acc;
  logic [15:0] char_cnt;
  logic [31:0] packed_chars;
  logic        kind_char;
  logic        data_init;
  logic [15:0] array_size;

  // Results of the transaction being decoded, and those still awaited.
  res_t      step_res [3];
  int        step_n;
  res_t      lit_results_q [$];
  stim_row_t directed_q [$];

  int   errors        = 0;
  int   idle_cycles   = 0;
  int   stall_left    = 0;
  int   calm_cycles   = 0;
  int   calm_items    = 0;
  int   counted_items = 0;
  res_t got_res;
  res_t want_res;

  c_literal_escape_decoder #(
    .CHAR_CONST_BYTES(CHAR_CONST_BYTES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .src_i (src_if),
    .res_o (res_if)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic res_t mk_res(logic [7:0] b, logic bv, logic cl, logic [31:0] cv,
                                  logic [2:0] st, logic la, logic last);
    res_t r;
    r.byte_value   = b;
    r.byte_valid   = bv;
    r.closed       = cl;
    r.char_value   = cv;
    r.status       = st;
    r.line_advance = la;
    r.is_last      = last;
    return r;
  endfunction

  function automatic void add_result(res_t r);
    step_res[step_n] = r;
    step_n++;
  endfunction

  function automatic void bump_count();
    if (char_cnt != 16'hFFFF) begin
      char_cnt++;
    end
  endfunction

  // Hands one decoded value to the constant: packed for a character constant,
  // emitted as a string byte otherwise, subject to the array size.
  function automatic void put_byte(logic [8:0] val);
    logic [7:0]  b;
    logic [31:0] ext;
    int          sh;
    b = val[7:0];
    if (kind_char) begin
      if (int'(char_cnt) < CHAR_CONST_BYTES && int'(char_cnt) < 4) begin
        ext = {{24{b[7]}}, b};
        sh = int'(char_cnt) * 8;
        packed_chars = (packed_chars & ((32'd1 << sh) - 32'd1)) | (ext << sh);
      end
    end else if (!data_init || array_size == 16'd0 || char_cnt < array_size) begin
      add_result(mk_res(b, 1'b1, 1'b0, 32'd0, ST_OK, 1'b0, 1'b0));
    end else if (char_cnt == array_size) begin
      add_result(mk_res(8'h00, 1'b0, 1'b0, 32'd0, ST_IGNORED, 1'b0, 1'b0));
    end
    bump_count();
  endfunction

  // Ends the constant; an error status given here wins over empty or too many.
  function automatic void close_literal(logic [2:0] st, logic la);
    logic [2:0] fin;
    fin = st;
    lit_open = 1'b0;
    esc_phase = PH_NONE;
    if (kind_char) begin
      if (fin == ST_OK) begin
        if (char_cnt == 16'd0) begin
          fin = ST_EMPTY;
        end else if (int'(char_cnt) > CHAR_CONST_BYTES) begin
          fin = ST_TOO_MANY;
        end
      end
      add_result(mk_res(8'h00, 1'b0, 1'b1, packed_chars, fin, la, 1'b0));
    end else if (!data_init || array_size == 16'd0 || char_cnt < array_size) begin
      add_result(mk_res(8'h00, 1'b1, 1'b1, 32'd0, fin, la, 1'b0));
    end else begin
      add_result(mk_res(8'h00, 1'b0, 1'b1, 32'd0, fin, la, 1'b0));
    end
  endfunction

  // A character outside any escape.
  function automatic void plain_char(logic [7:0] c, logic eoi);
    logic [7:0] closer;
    closer = kind_char ? CH_SQUOTE : CH_DQUOTE;
    if (eoi) begin
      close_literal(ST_EOF, 1'b0);
    end else if (c == closer) begin
      close_literal(ST_OK, 1'b0);
    end else if (c == CH_LF) begin
      close_literal(ST_NEWLINE, 1'b1);
    end else if (c == CH_BSLASH) begin
      esc_phase = PH_ESC;
    end else begin
      put_byte({1'b0, c});
    end
  endfunction

  // Decodes one accepted input transaction into step_res[0 .. step_n-1].
  function automatic void decode_item(item_t it);
    logic [7:0] c;
    logic [7:0] v;
    logic       eoi;
    logic       oct;
    c = it.ch;
    eoi = it.end_of_input;
    oct = (c >= CH_ZERO) && (c <= CH_SEVEN);
    step_n = 0;
    if (it.operation == OP_BEGIN) begin
      lit_open = 1'b1;
      esc_phase = PH_NONE;
      oct_acc = '0;
      char_cnt = '0;
      packed_chars = '0;
      kind_char = it.is_char_const;
      data_init = it.to_data;
      array_size = it.size_limit;
    end else if (lit_open) begin
      case (esc_phase)
        PH_ESC: begin
          esc_phase = PH_NONE;
          if (eoi) begin
            close_literal(ST_EOF, 1'b0);
          end else if (c == CH_LF) begin
            add_result(mk_res(8'h00, 1'b0, 1'b0, 32'd0, ST_OK, 1'b1, 1'b0));
          end else if (oct) begin
            oct_acc = {6'd0, c[2:0]};
            esc_phase = PH_OCT1;
          end else begin
            case (c)
              CH_LOW_N: v = CH_LF;
              CH_LOW_R: v = CH_CR;
              CH_LOW_B: v = CH_BS;
              CH_LOW_T: v = CH_TAB;
              CH_LOW_F: v = CH_FF;
              CH_LOW_V: v = CH_VT;
              default:  v = c;
            endcase
            put_byte({1'b0, v});
          end
        end
        PH_OCT1: begin
          if (!eoi && oct) begin
            oct_acc = {oct_acc[5:0], c[2:0]};
            esc_phase = PH_OCT2;
          end else begin
            esc_phase = PH_NONE;
            put_byte(oct_acc);
            plain_char(c, eoi);
          end
        end
        PH_OCT2: begin
          esc_phase = PH_NONE;
          if (!eoi && oct) begin
            oct_acc = {oct_acc[5:0], c[2:0]};
            put_byte(oct_acc);
          end else begin
            put_byte(oct_acc);
            plain_char(c, eoi);
          end
        end
        default: plain_char(c, eoi);
      endcase
      if (step_n > 0) begin
        step_res[step_n - 1].is_last = 1'b1;
      end
    end
  endfunction

  // Fields that the operation does not use carry random values.
  function automatic item_t filler();
    logic [27:0] raw;
    raw = 28'($urandom());
    return item_t'(raw);
  endfunction

  function automatic item_t begin_item(logic kind, logic data, logic [15:0] lim);
    item_t it;
    it = filler();
    it.operation = OP_BEGIN;
    it.is_char_const = kind;
    it.to_data = data;
    it.size_limit = lim;
    return it;
  endfunction

  function automatic item_t char_item(logic [7:0] c);
    item_t it;
    it = filler();
    it.operation = OP_CHAR;
    it.ch = c;
    it.end_of_input = 1'b0;
    return it;
  endfunction

  function automatic item_t eoi_item();
    item_t it;
    it = filler();
    it.operation = OP_CHAR;
    it.end_of_input = 1'b1;
    return it;
  endfunction

  function automatic void add_row(item_t it, bit typed, bit want_any, res_t want);
    stim_row_t row;
    row.it = it;
    row.typed = typed;
    row.want_any = want_any;
    row.want = want;
    directed_q.push_back(row);
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 24);
  endfunction

  // Drives one input transaction and records what it should produce. A typed
  // expectation replaces the predicted one.
  task automatic send(item_t it, bit typed, bit want_any, res_t want);
    int gap;
    gap = 0;
    if (calm_items > 0) begin
      calm_items--;
    end else begin
      if ($urandom_range(0, 49) == 0) begin
        calm_items = $urandom_range(10, 30);
      end
      gap = pick_gap();
    end
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_if.valid         <= 1'b1;
    src_if.operation     <= it.operation;
    src_if.ch            <= it.ch;
    src_if.end_of_input  <= it.end_of_input;
    src_if.is_char_const <= it.is_char_const;
    src_if.to_data       <= it.to_data;
    src_if.size_limit    <= it.size_limit;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
    decode_item(it);
    if (typed) begin
      step_n = want_any ? 1 : 0;
      step_res[0] = want;
    end
    for (int i = 0; i < step_n; i++) begin
      lit_results_q.push_back(step_res[i]);
    end
    counted_items++;
  endtask

  // One constant with random kind, size and body, mostly closed properly.
  task automatic send_random_literal();
    logic        kind;
    logic [7:0]  closer;
    logic [7:0]  c;
    logic [15:0] lim;
    int          len;
    int          r;
    bit          was_idle;
    kind = 1'($urandom_range(0, 1));
    closer = kind ? CH_SQUOTE : CH_DQUOTE;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      lim = 16'($urandom_range(0, 6));
    end else if (r < 75) begin
      lim = 16'd0;
    end else if (r < 90) begin
      lim = 16'($urandom());
    end else begin
      lim = 16'hFFFF;
    end
    send(begin_item(kind, 1'($urandom_range(0, 1)), lim), 1'b0, 1'b0, '0);
    len = kind ? $urandom_range(0, 6) : $urandom_range(0, 10);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        // Digits, letters and some punctuation; digits 8 and 9 end an octal run.
        c = 8'($urandom_range(32'h30, 32'h7A));
        if (c == CH_BSLASH) begin
          c = CH_LOW_T;
        end
        send(char_item(c), 1'b0, 1'b0, '0);
      end else if (r < 55) begin
        send(char_item(8'($urandom())), 1'b0, 1'b0, '0);
      end else if (r < 75) begin
        send(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
        case ($urandom_range(0, 9))
          0:       c = CH_LOW_N;
          1:       c = CH_LOW_R;
          2:       c = CH_LOW_B;
          3:       c = CH_LOW_T;
          4:       c = CH_LOW_F;
          5:       c = CH_LOW_V;
          6:       c = CH_SQUOTE;
          7:       c = CH_DQUOTE;
          8:       c = CH_BSLASH;
          default: c = 8'($urandom());
        endcase
        send(char_item(c), 1'b0, 1'b0, '0);
      end else if (r < 90) begin
        send(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
        repeat ($urandom_range(1, 3)) begin
          send(char_item(8'(CH_ZERO + 8'($urandom_range(0, 7)))), 1'b0, 1'b0, '0);
        end
      end else begin
        send(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
        send(char_item(CH_LF), 1'b0, 1'b0, '0);
      end
    end
    // Closing: the matching quote most of the time, else an error or nothing.
    r = $urandom_range(0, 99);
    if (r < 65) begin
      send(char_item(closer), 1'b0, 1'b0, '0);
    end else if (r < 75) begin
      send(char_item(CH_LF), 1'b0, 1'b0, '0);
    end else if (r < 85) begin
      send(eoi_item(), 1'b0, 1'b0, '0);
    end else if (r < 92) begin
      send(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
      send(eoi_item(), 1'b0, 1'b0, '0);
    end
    // Stray characters; those that reach an idle block do not count.
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        was_idle = !lit_open;
        if ($urandom_range(0, 3) == 0) begin
          send(eoi_item(), 1'b0, 1'b0, '0);
        end else begin
          send(char_item(8'($urandom())), 1'b0, 1'b0, '0);
        end
        if (was_idle) begin
          counted_items--;
        end
      end
    end
  endtask

  // Result side: random stalls, with quiet stretches in between.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_if.ready <= 1'b1;
      if (calm_cycles != 0) begin
        calm_cycles <= calm_cycles - 1;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left <= pick_gap();
      end else if ($urandom_range(0, 199) == 0) begin
        calm_cycles <= $urandom_range(40, 120);
      end
    end
  end

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_res = mk_res(res_if.byte_value, res_if.byte_valid, res_if.closed,
                       res_if.char_value, res_if.status, res_if.line_advance,
                       res_if.is_last);
      if (lit_results_q.size() == 0) begin
        errors++;
        $error("result with none expected: byte_value %0h status %0d closed %0b",
               got_res.byte_value, got_res.status, got_res.closed);
      end else begin
        want_res = lit_results_q.pop_front();
        if (got_res.byte_value !== want_res.byte_value) begin
          errors++;
          $error("byte_value: expected %0h, actual %0h", want_res.byte_value,
                 got_res.byte_value);
        end
        if (got_res.byte_valid !== want_res.byte_valid) begin
          errors++;
          $error("byte_valid: expected %0b, actual %0b", want_res.byte_valid,
                 got_res.byte_valid);
        end
        if (got_res.closed !== want_res.closed) begin
          errors++;
          $error("closed: expected %0b, actual %0b", want_res.closed, got_res.closed);
        end
        if (got_res.char_value !== want_res.char_value) begin
          errors++;
          $error("char_value: expected %0d, actual %0d", want_res.char_value,
                 got_res.char_value);
        end
        if (got_res.status !== want_res.status) begin
          errors++;
          $error("status: expected %0d, actual %0d", want_res.status, got_res.status);
        end
        if (got_res.line_advance !== want_res.line_advance) begin
          errors++;
          $error("line_advance: expected %0b, actual %0b", want_res.line_advance,
                 got_res.line_advance);
        end
        if (got_res.is_last !== want_res.is_last) begin
          errors++;
          $error("is_last: expected %0b, actual %0b", want_res.is_last, got_res.is_last);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk_i) begin
    if ((src_if.valid && src_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    src_if.valid         <= 1'b0;
    src_if.operation     <= OP_BEGIN;
    src_if.ch            <= 8'h00;
    src_if.end_of_input  <= 1'b0;
    src_if.is_char_const <= 1'b0;
    src_if.to_data       <= 1'b0;
    src_if.size_limit    <= 16'h0000;
    lit_open     = 1'b0;
    esc_phase    = PH_NONE;
    oct_acc      = '0;
    char_cnt     = '0;
    packed_chars = '0;
    kind_char    = 1'b0;
    data_init    = 1'b0;
    array_size   = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Character before any constant is opened: ignored.
    add_row(char_item(8'h61), 1'b1, 1'b0, '0);
    // Empty character constant.
    add_row(begin_item(1'b1, 1'b0, 16'd0), 1'b0, 1'b0, '0);
    add_row(char_item(CH_SQUOTE), 1'b1, 1'b1,
            mk_res(8'h00, 1'b0, 1'b1, 32'd0, ST_EMPTY, 1'b0, 1'b1));
    // String into data with room for two bytes: the third is reported, then
    // a newline ends it without a closing null.
    add_row(begin_item(1'b0, 1'b1, 16'd2), 1'b0, 1'b0, '0);
    add_row(char_item(8'hFF), 1'b1, 1'b1,
            mk_res(8'hFF, 1'b1, 1'b0, 32'd0, ST_OK, 1'b0, 1'b1));
    add_row(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
    add_row(char_item(CH_LOW_V), 1'b0, 1'b0, '0);
    add_row(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
    add_row(char_item(CH_SEVEN), 1'b0, 1'b0, '0);
    add_row(char_item(CH_SEVEN), 1'b0, 1'b0, '0);
    add_row(char_item(CH_SEVEN), 1'b1, 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 32'd0, ST_IGNORED, 1'b0, 1'b1));
    add_row(char_item(CH_LF), 1'b1, 1'b1,
            mk_res(8'h00, 1'b0, 1'b1, 32'd0, ST_NEWLINE, 1'b1, 1'b1));
    // String not into data: line continuation, short octal run ended by a
    // letter, then a backslash cut off by the end of input.
    add_row(begin_item(1'b0, 1'b0, 16'hFFFF), 1'b0, 1'b0, '0);
    add_row(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
    add_row(char_item(CH_LF), 1'b1, 1'b1,
            mk_res(8'h00, 1'b0, 1'b0, 32'd0, ST_OK, 1'b1, 1'b1));
    add_row(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
    add_row(char_item(8'(CH_ZERO + 8'd1)), 1'b0, 1'b0, '0);
    add_row(char_item(8'h7A), 1'b0, 1'b0, '0);
    add_row(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
    add_row(eoi_item(), 1'b1, 1'b1,
            mk_res(8'h00, 1'b1, 1'b1, 32'd0, ST_EOF, 1'b0, 1'b1));
    // Character constant with a negative byte and an octal run ended by the quote.
    add_row(begin_item(1'b1, 1'b1, 16'd0), 1'b0, 1'b0, '0);
    add_row(char_item(8'h80), 1'b0, 1'b0, '0);
    add_row(char_item(CH_BSLASH), 1'b0, 1'b0, '0);
    add_row(char_item(8'(CH_ZERO + 8'd3)), 1'b0, 1'b0, '0);
    add_row(char_item(CH_SQUOTE), 1'b0, 1'b0, '0);

    foreach (directed_q[i]) begin
      send(directed_q[i].it, directed_q[i].typed, directed_q[i].want_any,
           directed_q[i].want);
    end

    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      send_random_literal();
    end

    src_if.valid <= 1'b0;
    while (lit_results_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
